// File: sv/rdd_pkg.sv
// Shared constants, types and codes of the deadlock detector.
`timescale 1ns / 1ps

package rdd_pkg;

   localparam int MAX_REQUESTERS = 16;
   localparam int RESOURCE_COUNT = 4;
   localparam int MIN_CHECK_ROWS = 4;

   localparam int REQ_INDEX_W = 4;
   localparam int RES_INDEX_W = 2;
   localparam int CELL_W      = 2;
   localparam int COUNT_W     = 5;
   localparam int COUNT_RESET = 16;

   localparam int ROW_W = $clog2(MAX_REQUESTERS);
   localparam int CNT_W = $clog2(MAX_REQUESTERS + 1);

   typedef logic [CELL_W-1:0] cell_type;
   typedef cell_type [RESOURCE_COUNT-1:0] row_type;
   typedef logic [RESOURCE_COUNT-1:0] res_mask_type;

   localparam cell_type CELL_IDLE       = 2'd0;
   localparam cell_type CELL_REQUESTING = 2'd1;
   localparam cell_type CELL_HOLDING    = 2'd2;

   typedef struct packed {
      logic         alive;
      logic         killed;
      res_mask_type hold;
   } eval_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SWEEP  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

// File: sv/rdd_cell_table.sv
// Requester-by-resource cell table with one cell write and one row read.
`timescale 1ns / 1ps

module rdd_cell_table (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [rdd_pkg::ROW_W-1:0]       wr_row,
   input  logic [rdd_pkg::RES_INDEX_W-1:0] wr_col,
   input  rdd_pkg::cell_type       wr_cell,
   input  logic [rdd_pkg::ROW_W-1:0]       rd_row,
   output rdd_pkg::row_type        rd_data
);

   rdd_pkg::row_type rows_ff [rdd_pkg::MAX_REQUESTERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rdd_pkg::MAX_REQUESTERS; i++) begin
            rows_ff[i] <= '0;
         end
      end else if (wr_en) begin
         rows_ff[wr_row][wr_col] <= wr_cell;
      end
   end

   assign rd_data = rows_ff[rd_row];

endmodule

// File: sv/rdd_row_eval.sv
// Peel step for one requester row: keep or drop the row, collect held resources.
`timescale 1ns / 1ps

module rdd_row_eval (
   input  rdd_pkg::row_type      row,
   input  rdd_pkg::res_mask_type res_alive,
   input  logic                  req_alive,
   output rdd_pkg::eval_type     result
);

   rdd_pkg::res_mask_type wants;
   rdd_pkg::res_mask_type holds;

   always_comb begin
      for (int j = 0; j < rdd_pkg::RESOURCE_COUNT; j++) begin
         wants[j] = (row[j] == rdd_pkg::CELL_REQUESTING);
         holds[j] = (row[j] == rdd_pkg::CELL_HOLDING);
      end
      result.alive  = req_alive && ((wants & res_alive) != '0);
      result.killed = req_alive && !result.alive;
      result.hold   = result.alive ? holds : '0;
   end

endmodule

// File: sv/rag_deadlock_detector_unit.sv
// Deadlock detector top level: cell table, peel sequencer and result register.
//
// Usage: each transfer on the req_ channel writes one cell (requester row,
// resource column, state) and yields exactly one rsp_ transfer whose
// rsp_deadlock bit tells whether the resource allocation graph now holds a
// directed cycle. csr_ writes set the number of requester rows in use; the
// graph is checked only when more than four rows are in use.
// Sequencing: with four or fewer rows, the item goes straight to the finish
// state. Otherwise the shared row evaluator sweeps the rows in use once per
// pass, one row a cycle, and repeats passes until nothing is peeled, at most
// 21 passes for 16 rows; the finish state then loads the output register.
// Throughput: one item at a time; req_stall is high from accept until the
// result is loaded into the output register.
// Reset: all cells idle, row count 16, no result pending.
// A stalled result holds in the output register; the next item may be
// accepted meanwhile, and its result waits until the register frees.
`timescale 1ns / 1ps

module rag_deadlock_detector_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rdd_pkg::REQ_INDEX_W-1:0] req_requester_index,
   input  logic [rdd_pkg::RES_INDEX_W-1:0] req_resource_index,
   input  logic [rdd_pkg::CELL_W-1:0]      req_cell_state,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_deadlock,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rdd_pkg::COUNT_W-1:0]     csr_requester_count
);

   rdd_pkg::state_type state_ff, state_in;
   logic [rdd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [rdd_pkg::ROW_W-1:0]   idx_ff, idx_in;
   logic                        req_alive_ff [rdd_pkg::MAX_REQUESTERS];
   rdd_pkg::res_mask_type       res_alive_ff, res_alive_in;
   rdd_pkg::res_mask_type       hold_acc_ff, hold_acc_in;
   logic                        changed_ff, changed_in;
   logic                        any_alive_ff, any_alive_in;
   logic                        result_ff, result_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_deadlock_ff, rsp_deadlock_in;

   logic                        req_accept;
   logic                        table_wr_en;
   logic [rdd_pkg::CNT_W-1:0]   rows_in_use;
   logic                        last_row;
   logic                        rsp_load;
   rdd_pkg::row_type            rd_row_data;
   rdd_pkg::eval_type           eval;
   rdd_pkg::res_mask_type       res_next;

   assign req_stall  = (state_ff != rdd_pkg::ST_IDLE);
   assign csr_ready  = (state_ff == rdd_pkg::ST_IDLE) && !req_valid;
   assign req_accept = req_valid && !req_stall;
   assign table_wr_en = req_accept &&
                        (int'(req_requester_index) < rdd_pkg::MAX_REQUESTERS);

   assign rows_in_use = (int'(count_ff) > rdd_pkg::MAX_REQUESTERS) ?
                        rdd_pkg::CNT_W'(rdd_pkg::MAX_REQUESTERS) :
                        rdd_pkg::CNT_W'(count_ff);
   assign last_row = (rdd_pkg::CNT_W'(idx_ff) == rows_in_use - rdd_pkg::CNT_W'(1));

   rdd_cell_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (table_wr_en),
      .wr_row  (rdd_pkg::ROW_W'(req_requester_index)),
      .wr_col  (req_resource_index),
      .wr_cell (req_cell_state),
      .rd_row  (idx_ff),
      .rd_data (rd_row_data)
   );

   rdd_row_eval u_eval (
      .row       (rd_row_data),
      .res_alive (res_alive_ff),
      .req_alive (req_alive_ff[idx_ff]),
      .result    (eval)
   );

   assign res_next = res_alive_ff & (hold_acc_ff | eval.hold);
   assign rsp_load = (state_ff == rdd_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      res_alive_in    = res_alive_ff;
      hold_acc_in     = hold_acc_ff;
      changed_in      = changed_ff;
      any_alive_in    = any_alive_ff;
      result_in       = result_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_deadlock_in = rsp_deadlock_ff;

      if (csr_valid && csr_ready) begin
         count_in = csr_requester_count;
      end

      case (state_ff)
         rdd_pkg::ST_IDLE: begin
            if (req_accept) begin
               idx_in       = '0;
               res_alive_in = '1;
               hold_acc_in  = '0;
               changed_in   = 1'b0;
               any_alive_in = 1'b0;
               result_in    = 1'b0;
               if (rows_in_use > rdd_pkg::CNT_W'(rdd_pkg::MIN_CHECK_ROWS)) begin
                  state_in = rdd_pkg::ST_SWEEP;
               end else begin
                  state_in = rdd_pkg::ST_FINISH;
               end
            end
         end
         rdd_pkg::ST_SWEEP: begin
            hold_acc_in  = hold_acc_ff | eval.hold;
            changed_in   = changed_ff | eval.killed;
            any_alive_in = any_alive_ff | eval.alive;
            idx_in       = idx_ff + rdd_pkg::ROW_W'(1);
            if (last_row) begin
               idx_in       = '0;
               hold_acc_in  = '0;
               changed_in   = 1'b0;
               any_alive_in = 1'b0;
               res_alive_in = res_next;
               if (!(changed_ff || eval.killed || (res_next != res_alive_ff))) begin
                  result_in = any_alive_ff || eval.alive || (res_alive_ff != '0);
                  state_in  = rdd_pkg::ST_FINISH;
               end
            end
         end
         rdd_pkg::ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in    = 1'b1;
               rsp_deadlock_in = result_ff;
               state_in        = rdd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rdd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdd_pkg::ST_IDLE;
         count_ff     <= rdd_pkg::COUNT_W'(rdd_pkg::COUNT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      res_alive_ff    <= res_alive_in;
      hold_acc_ff     <= hold_acc_in;
      changed_ff      <= changed_in;
      any_alive_ff    <= any_alive_in;
      result_ff       <= result_in;
      rsp_deadlock_ff <= rsp_deadlock_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == rdd_pkg::ST_IDLE && req_accept) begin
         for (int i = 0; i < rdd_pkg::MAX_REQUESTERS; i++) begin
            req_alive_ff[i] <= 1'b1;
         end
      end else if (state_ff == rdd_pkg::ST_SWEEP) begin
         req_alive_ff[idx_ff] <= eval.alive;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_deadlock = rsp_deadlock_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != rdd_pkg::ST_IDLE))
      else $error("accepted item did not start work");

   a_sweep_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdd_pkg::ST_SWEEP) |-> (rdd_pkg::CNT_W'(idx_ff) < rows_in_use))
      else $error("sweep index beyond rows in use");

   a_resources_only_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdd_pkg::ST_SWEEP && $past(state_ff) == rdd_pkg::ST_SWEEP) |->
      ((res_alive_ff & ~$past(res_alive_ff)) == '0))
      else $error("peeled resource came back");

   a_small_count_no_deadlock: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdd_pkg::ST_FINISH &&
       rows_in_use <= rdd_pkg::CNT_W'(rdd_pkg::MIN_CHECK_ROWS)) |-> !result_ff)
      else $error("deadlock flagged with too few rows in use");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");
`endif

endmodule
